// ===== src/tcce_pkg.sv =====
// Shared types and constants for the text console character engine.
// Used by the interfaces, the front and back modules and the top level.
package tcce_pkg;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [7:0]  CH_ESC     = 8'h1B;
  localparam logic [7:0]  CH_CLEAR   = 8'h1A;
  localparam logic [7:0]  CH_ROWBLNK = 8'h19;
  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  RESET_COLS = 8'd80;
  localparam logic [5:0]  RESET_ROWS = 6'd25;
  localparam logic        FUNC_PRINT = 1'b0;
  localparam logic        FUNC_READ  = 1'b1;
  localparam logic        REG_COLS   = 1'b0;
  localparam logic        REG_ROWS   = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } in_word_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        escape_pending;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRAP,
    ST_FILL,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_DONE
  } back_state_t;

endpackage

// ===== src/tcce_if.sv =====
// Valid/ready channel interfaces for the console engine.
// Depends on tcce_pkg for the payload types.
interface tcce_in_if;
  logic               valid;
  logic               ready;
  tcce_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcce_out_if;
  logic                valid;
  logic                ready;
  tcce_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcce_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== src/tcce_front.sv =====
// Front end: accepts input words into a two-entry queue for the back end.
// Depends on tcce_pkg.
module tcce_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcce_pkg::in_word_t  in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output tcce_pkg::in_word_t  q_data
);
  tcce_pkg::in_word_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = cnt_r != 2'd2;
  assign q_valid  = cnt_r != 2'd0;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

// ===== src/tcce_back.sv =====
// Back end: cursor logic, screen store, clear, row blank and scroll sequences.
// Depends on tcce_pkg.
module tcce_back #(
  parameter int COL_W = 7,
  parameter int ROW_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  tcce_pkg::in_word_t  q_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output tcce_pkg::out_word_t out_data
);
  localparam int DEPTH = (1 << COL_W) * (1 << ROW_W);
  localparam int AW    = COL_W + ROW_W;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_r;

  tcce_pkg::back_state_t st_r, st_nxt;
  logic [COL_W-1:0] cx_r, cx_nxt;
  logic [ROW_W-1:0] cy_r, cy_nxt;
  logic [7:0] attr_r, attr_nxt;
  logic esc_r, esc_nxt;
  logic [7:0] cols_r;
  logic [5:0] rows_r;
  logic [COL_W:0] sc_r, sc_nxt;
  logic [ROW_W:0] sr_r, sr_nxt, fend_r, fend_nxt;
  logic [ROW_W:0] ny_r, ny_nxt;
  logic [COL_W:0] nx_r, nx_nxt;
  logic init_r, init_nxt;
  logic rdres_r, rdres_nxt;
  logic [COL_W+1:0] w_ext;
  logic [ROW_W+1:0] h_ext;
  logic [COL_W:0] w;
  logic [ROW_W:0] h;
  logic we;
  logic re;
  logic [AW-1:0] wa, ra;
  logic [15:0] wd;
  logic [COL_W+1:0] cx_e;
  logic [ROW_W+1:0] cy_e;
  logic [COL_W+1:0] tx;
  logic [ROW_W+1:0] ty;
  logic [7:0] ch;
  logic [COL_W:0] rc;
  logic [ROW_W:0] rr;

  // Effective size: zero means one, oversize saturates.
  always_comb begin
    w_ext = (COL_W+2)'(cols_r);
    if (cols_r == 8'd0) w_ext = (COL_W+2)'(1);
    else if (w_ext > (COL_W+2)'(1 << COL_W)) w_ext = (COL_W+2)'(1 << COL_W);
    h_ext = (ROW_W+2)'(rows_r);
    if (rows_r == 6'd0) h_ext = (ROW_W+2)'(1);
    else if (h_ext > (ROW_W+2)'(1 << ROW_W)) h_ext = (ROW_W+2)'(1 << ROW_W);
    w = w_ext[COL_W:0];
    h = h_ext[ROW_W:0];
  end

  assign ch = q_data.char_byte;
  assign rc = (COL_W+1)'(q_data.read_col);
  assign rr = (ROW_W+1)'(q_data.read_row);

  // The read register only loads on a real read, so a cell fetched for a
  // result word stays put while the result waits.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_r <= mem[ra];
  end

  always_comb begin
    st_nxt = st_r; cx_nxt = cx_r; cy_nxt = cy_r; attr_nxt = attr_r;
    esc_nxt = esc_r; sc_nxt = sc_r; sr_nxt = sr_r; fend_nxt = fend_r;
    ny_nxt = ny_r; nx_nxt = nx_r; init_nxt = init_r; rdres_nxt = rdres_r;
    we = 1'b0; re = 1'b0; wa = '0; wd = tcce_pkg::BLANK_CELL; ra = '0;
    q_ready = 1'b0;
    cx_e = (COL_W+2)'(cx_r); cy_e = (ROW_W+2)'(cy_r);
    tx = cx_e; ty = cy_e;
    case (st_r)
      tcce_pkg::ST_IDLE: begin
        if (init_r) begin
          // Power-on clearing pass over the whole store.
          we = 1'b1; wa = {sr_r[ROW_W-1:0], sc_r[COL_W-1:0]};
          sc_nxt = sc_r + 1'b1;
          if (sc_r[COL_W-1:0] == '1) begin
            sc_nxt = '0; sr_nxt = sr_r + 1'b1;
            if (sr_r[ROW_W-1:0] == '1) begin init_nxt = 1'b0; sr_nxt = '0; end
          end
        end else if (q_valid) begin
          q_ready = 1'b1;
          rdres_nxt = 1'b0;
          if (q_data.func == tcce_pkg::FUNC_READ) begin
            re = 1'b1;
            ra = {q_data.read_row[ROW_W-1:0], q_data.read_col[COL_W-1:0]};
            rdres_nxt = (rc < (COL_W+1)'(1 << COL_W)) && (rr < (ROW_W+1)'(1 << ROW_W));
            st_nxt = tcce_pkg::ST_READ;
          end else if (esc_r) begin
            attr_nxt = ch; esc_nxt = 1'b0; st_nxt = tcce_pkg::ST_DONE;
          end else if (ch == tcce_pkg::CH_ESC) begin
            esc_nxt = 1'b1; st_nxt = tcce_pkg::ST_DONE;
          end else begin
            st_nxt = tcce_pkg::ST_WRAP;
            if (ch == tcce_pkg::CH_CLEAR) begin
              tx = '0; ty = '0; sc_nxt = '0; sr_nxt = '0;
              fend_nxt = h; st_nxt = tcce_pkg::ST_FILL;
            end else if (ch == tcce_pkg::CH_ROWBLNK) begin
              tx = '0; sc_nxt = '0; sr_nxt = (ROW_W+1)'(cy_r);
              fend_nxt = (ROW_W+1)'(cy_r) + 1'b1; st_nxt = tcce_pkg::ST_FILL;
            end else if (ch == tcce_pkg::CH_BS) begin
              if (cx_r != '0) tx = cx_e - 1'b1;
            end else if (ch == tcce_pkg::CH_TAB) begin
              tx = (cx_e + (COL_W+2)'(4)) & ~(COL_W+2)'(3);
            end else if (ch == tcce_pkg::CH_CR) begin
              tx = '0;
            end else if (ch == tcce_pkg::CH_LF) begin
              tx = '0; ty = cy_e + 1'b1;
            end else if (ch >= 8'h20 && ch <= 8'h7F) begin
              tx = cx_e + 1'b1;
              we = 1'b1; wa = {cy_r, cx_r}; wd = {attr_r, ch};
            end
            nx_nxt = tx[COL_W:0];
            ny_nxt = ty[ROW_W:0];
          end
        end
      end
      tcce_pkg::ST_READ: begin
        st_nxt = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_FILL: begin
        // Blank rows sr..fend-1 over columns 0..w-1.
        we = 1'b1; wa = {sr_r[ROW_W-1:0], sc_r[COL_W-1:0]};
        if (sr_r >= (ROW_W+1)'(1 << ROW_W)) we = 1'b0;
        sc_nxt = sc_r + 1'b1;
        if (sc_r + 1'b1 >= w) begin
          sc_nxt = '0; sr_nxt = sr_r + 1'b1;
          if (sr_r + 1'b1 >= fend_r) st_nxt = tcce_pkg::ST_WRAP;
        end
      end
      tcce_pkg::ST_WRAP: begin
        if (nx_r >= w) begin nx_nxt = '0; ny_nxt = ny_r + 1'b1; end
        st_nxt = tcce_pkg::ST_DONE;
        if (((nx_r >= w) ? ny_r + 1'b1 : ny_r) >= h) begin
          sc_nxt = '0; sr_nxt = (ROW_W+1)'(1);
          if (h == (ROW_W+1)'(1)) begin
            sr_nxt = '0; fend_nxt = (ROW_W+1)'(1); st_nxt = tcce_pkg::ST_FILL;
          end else st_nxt = tcce_pkg::ST_SCR_RD;
          ny_nxt = h - 1'b1;
        end
        if (st_nxt == tcce_pkg::ST_DONE) begin
          cx_nxt = nx_nxt[COL_W-1:0]; cy_nxt = ny_nxt[ROW_W-1:0];
        end
      end
      tcce_pkg::ST_SCR_RD: begin
        re = 1'b1;
        ra = {sr_r[ROW_W-1:0], sc_r[COL_W-1:0]};
        st_nxt = tcce_pkg::ST_SCR_WR;
      end
      tcce_pkg::ST_SCR_WR: begin
        we = 1'b1; wd = rd_r;
        wa = {sr_r[ROW_W-1:0] - 1'b1, sc_r[COL_W-1:0]};
        st_nxt = tcce_pkg::ST_SCR_RD;
        sc_nxt = sc_r + 1'b1;
        if (sc_r + 1'b1 >= w) begin
          sc_nxt = '0; sr_nxt = sr_r + 1'b1;
          if (sr_r + 1'b1 >= h) begin
            sr_nxt = h - 1'b1; fend_nxt = h; st_nxt = tcce_pkg::ST_FILL;
          end
        end
      end
      tcce_pkg::ST_DONE: begin
        if (out_ready) st_nxt = tcce_pkg::ST_IDLE;
      end
      default: st_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  // After a scroll ends in a fill the cursor is committed in ST_WRAP again;
  // nx/ny already hold in-range values then, so the checks pass through.
  assign out_valid = (st_r == tcce_pkg::ST_DONE);
  always_comb begin
    out_data.cell_data      = rdres_r ? rd_r : 16'h0000;
    out_data.cursor_col     = 7'(cx_r);
    out_data.cursor_row     = 5'(cy_r);
    out_data.escape_pending = esc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tcce_pkg::ST_IDLE; cx_r <= '0; cy_r <= '0;
      attr_r <= tcce_pkg::RESET_ATTR; esc_r <= 1'b0;
      cols_r <= tcce_pkg::RESET_COLS; rows_r <= tcce_pkg::RESET_ROWS;
      sc_r <= '0; sr_r <= '0; fend_r <= '0; nx_r <= '0; ny_r <= '0;
      init_r <= 1'b1; rdres_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt; attr_r <= attr_nxt;
      esc_r <= esc_nxt; sc_r <= sc_nxt; sr_r <= sr_nxt; fend_r <= fend_nxt;
      nx_r <= nx_nxt; ny_r <= ny_nxt; init_r <= init_nxt; rdres_r <= rdres_nxt;
      if (cfg_we && cfg_index == tcce_pkg::REG_COLS) cols_r <= cfg_wdata;
      if (cfg_we && cfg_index == tcce_pkg::REG_ROWS) rows_r <= cfg_wdata[5:0];
    end
  end

`ifndef SYNTHESIS
  a_no_take_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !q_ready) else $error("item taken during clearing pass");
  a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == tcce_pkg::ST_DONE) else $error("result outside done");
  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(cx_r) && $stable(rd_r))
    else $error("result dropped");
`endif
endmodule

// ===== src/text_console_character_engine.sv =====
// Top level of the text console character engine.
// Depends on tcce_pkg, tcce_if, tcce_front and tcce_back.
//
// Input words (func, char_byte, read_col, read_row) enter on the in_ channel
// through a two-word queue; each gives one result word on the out_ channel
// with the cell read (zero for a print), the cursor and the escape flag.
// The cfg_ channel writes register 0 (columns) or 1 (rows); the user is to
// write while idle, which the block does not enforce. A read, print or cursor
// control byte passes the queue, then the back end's accept, step and result
// states; an escape or attribute byte skips the step state. The back end takes
// a new word only once the result word of the last has been taken. Clear adds
// a fill of w*h cells and row blank one of w cells; a scroll copies w*(h-1)
// cells up, reading then writing each, and blanks w; one store access a cycle.
// After reset all 2^(COL_W+ROW_W) cells (4096 by default) are swept to blank,
// one cell a cycle; words wait in the queue meanwhile. Results are held until
// out_ready; the queue fills then in_ready drops.
module text_console_character_engine #(
  parameter int COL_W = 7,
  parameter int ROW_W = 5
) (
  input logic       clk,
  input logic       rst_n,
  tcce_in_if.sink   in_ch,
  tcce_out_if.source out_ch,
  tcce_cfg_if.sink  cfg_ch
);
  logic               q_valid, q_ready;
  tcce_pkg::in_word_t q_data;

  assign cfg_ch.ready = 1'b1;

  tcce_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_ready, .q_data
  );

  tcce_back #(.COL_W(COL_W), .ROW_W(ROW_W)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_wdata(cfg_ch.wdata),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ===== test/tb.sv =====
// Testbench for the text console character engine.
// It keeps its own copy of the screen, cursor and attribute and checks every result word.
// Depends on tcce_pkg, tcce_if and text_console_character_engine.
`timescale 1ns / 1ps

module tb;

  logic clk;
  logic rst_n;

  tcce_in_if  in_if ();
  tcce_out_if out_if ();
  tcce_cfg_if cfg_if ();

  text_console_character_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  localparam int SCR_COLS = 128;
  localparam int SCR_ROWS = 32;

  // Our copy of the console state.
  logic [15:0] screen_image [SCR_COLS*SCR_ROWS];
  int          cur_x;
  int          cur_y;
  logic [7:0]  cur_attr;
  logic        esc_armed;
  logic [7:0]  width_reg;
  logic [5:0]  height_reg;

  tcce_pkg::out_word_t expected_words [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void put_cell(int x, int y, logic [15:0] v);
    if (x < SCR_COLS && y < SCR_ROWS) screen_image[y*SCR_COLS + x] = v;
  endfunction

  function automatic logic [15:0] get_cell(int x, int y);
    if (x < SCR_COLS && y < SCR_ROWS) return screen_image[y*SCR_COLS + x];
    return 16'h0000;
  endfunction

  function automatic void blank_line(int y, int w);
    for (int x = 0; x < w; x++) put_cell(x, y, tcce_pkg::BLANK_CELL);
  endfunction

  function automatic tcce_pkg::out_word_t console_step(tcce_pkg::in_word_t w);
    tcce_pkg::out_word_t r;
    int        wd;
    int        ht;
    int        x;
    int        y;
    r = '0;
    if (w.func == tcce_pkg::FUNC_READ) begin
      r.cell_data = get_cell(w.read_col, w.read_row);
    end else if (esc_armed) begin
      cur_attr  = w.char_byte;
      esc_armed = 1'b0;
    end else if (w.char_byte == tcce_pkg::CH_ESC) begin
      esc_armed = 1'b1;
    end else begin
      wd = (width_reg == 0) ? 1 : (width_reg > SCR_COLS) ? SCR_COLS : width_reg;
      ht = (height_reg == 0) ? 1 : (height_reg > SCR_ROWS) ? SCR_ROWS : height_reg;
      x = cur_x;
      y = cur_y;
      case (w.char_byte)
        tcce_pkg::CH_CLEAR: begin
          for (int rr = 0; rr < ht; rr++) blank_line(rr, wd);
          x = 0;
          y = 0;
        end
        tcce_pkg::CH_ROWBLNK: begin
          blank_line(y, wd);
          x = 0;
        end
        tcce_pkg::CH_BS:  if (x != 0) x--;
        tcce_pkg::CH_TAB: x = (x + 4) & ~3;
        tcce_pkg::CH_CR:  x = 0;
        tcce_pkg::CH_LF: begin
          x = 0;
          y++;
        end
        default: begin
          if (w.char_byte >= 8'h20 && w.char_byte <= 8'h7F) begin
            put_cell(x, y, {cur_attr, w.char_byte});
            x++;
          end
        end
      endcase
      if (x >= wd) begin
        x = 0;
        y++;
      end
      if (y >= ht) begin
        for (int rr = 1; rr < ht; rr++)
          for (int c = 0; c < wd; c++) put_cell(c, rr - 1, get_cell(c, rr));
        blank_line(ht - 1, wd);
        y = ht - 1;
      end
      cur_x = x;
      cur_y = y;
    end
    r.cursor_col     = cur_x[6:0];
    r.cursor_row     = cur_y[4:0];
    r.escape_pending = esc_armed;
    return r;
  endfunction

  // Result checker: every accepted word is matched against the oldest prediction.
  always @(posedge clk) begin
    tcce_pkg::out_word_t got;
    tcce_pkg::out_word_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", got);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got.cell_data !== want.cell_data) begin
            $error("cell_data expected %h actual %h", want.cell_data, got.cell_data);
            mismatches++;
          end
          if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col expected %0d actual %0d", want.cursor_col, got.cursor_col);
            mismatches++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d actual %0d", want.cursor_row, got.cursor_row);
            mismatches++;
          end
          if (got.escape_pending !== want.escape_pending) begin
            $error("escape_pending expected %0d actual %0d",
                   want.escape_pending, got.escape_pending);
            mismatches++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(tcce_pkg::in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
    expected_words.push_back(console_step(w));
  endtask

  task automatic send_print(logic [7:0] b);
    tcce_pkg::in_word_t w;
    w = '0;
    w.func = tcce_pkg::FUNC_PRINT;
    w.char_byte = b;
    w.read_col = 7'($urandom);
    w.read_row = 5'($urandom);
    send_word(w);
  endtask

  task automatic send_read(logic [6:0] c, logic [4:0] r);
    tcce_pkg::in_word_t w;
    w.func = tcce_pkg::FUNC_READ;
    w.char_byte = 8'($urandom);
    w.read_col = c;
    w.read_row = r;
    send_word(w);
  endtask

  // Waits until every predicted word has come back; the sender stays idle.
  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == tcce_pkg::REG_COLS) width_reg = val;
    else height_reg = val[5:0];
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(logic [7:0] cols, logic [7:0] rows);
    drain();
    write_reg(tcce_pkg::REG_COLS, cols);
    write_reg(tcce_pkg::REG_ROWS, rows);
  endtask

  task automatic send_random_word;
    int sel;
    sel = $urandom_range(99);
    if (sel < 48)      send_print(8'($urandom_range(8'h7F, 8'h20)));
    else if (sel < 60) send_read(7'($urandom), 5'($urandom));
    else if (sel < 66) send_print(tcce_pkg::CH_LF);
    else if (sel < 69) send_print(tcce_pkg::CH_CR);
    else if (sel < 72) send_print(tcce_pkg::CH_BS);
    else if (sel < 75) send_print(tcce_pkg::CH_TAB);
    else if (sel < 80) begin
      send_print(tcce_pkg::CH_ESC);
      send_print(8'($urandom));
    end
    else if (sel < 81) send_print(tcce_pkg::CH_CLEAR);
    else if (sel < 83) send_print(tcce_pkg::CH_ROWBLNK);
    else               send_print(8'($urandom));
  endtask

  task automatic test_directed;
    send_read(7'd0, 5'd0);
    send_print(8'h20);
    send_print(8'h7F);
    send_print(8'h41);
    send_print(8'h00);
    send_print(8'h80);
    send_print(8'hFF);
    send_print(tcce_pkg::CH_ESC);
    send_print(tcce_pkg::CH_ESC);     // escape byte taken as the attribute
    send_print(8'h5A);
    send_print(tcce_pkg::CH_ESC);
    send_print(8'hFF);
    send_print(tcce_pkg::CH_TAB);
    send_print(tcce_pkg::CH_BS);
    send_print(tcce_pkg::CH_CR);
    send_print(tcce_pkg::CH_BS);      // backspace at column zero
    send_print(tcce_pkg::CH_LF);
    send_print(8'h42);
    send_print(tcce_pkg::CH_ROWBLNK);
    send_read(7'd1, 5'd0);
    send_read(7'd127, 5'd31);
    send_print(tcce_pkg::CH_CLEAR);
    send_read(7'd0, 5'd0);
  endtask

  // The sender stops until the block has returned everything, then carries on.
  task automatic test_pause_for_drain;
    set_screen(8'd10, 8'd3);
    for (int i = 0; i < 30; i++) send_random_word();
    drain();
    for (int i = 0; i < 30; i++) send_random_word();
  endtask

  task automatic test_random_phases;
    logic [7:0] cols [10] = '{8'd8, 8'd1, 8'd0, 8'd16, 8'd128, 8'd3, 8'd255, 8'd40, 8'd128, 8'd80};
    logic [7:0] rows [10] = '{8'd4, 8'd1, 8'd0, 8'd8, 8'd2, 8'd32, 8'd63, 8'd12, 8'd32, 8'd25};
    int         count [10] = '{230, 200, 100, 250, 150, 200, 40, 250, 40, 200};
    for (int p = 0; p < 10; p++) begin
      set_screen(cols[p], rows[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int i = 0; i < count[p]; i++) send_random_word();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = tcce_pkg::REG_COLS;
    cfg_if.wdata   = '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < SCR_COLS*SCR_ROWS; i++) screen_image[i] = tcce_pkg::BLANK_CELL;
    cur_x      = 0;
    cur_y      = 0;
    cur_attr   = tcce_pkg::RESET_ATTR;
    esc_armed  = 1'b0;
    width_reg  = tcce_pkg::RESET_COLS;
    height_reg = tcce_pkg::RESET_ROWS;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pause_for_drain();
    test_random_phases();

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== text_console_character_engine.f =====
src/tcce_pkg.sv
src/tcce_if.sv
src/tcce_front.sv
src/tcce_back.sv
src/text_console_character_engine.sv
test/tb.sv
